### hw/rtl/mefst_pkg.sv
// shared types, constants and helpers of the midi event filter and state tracker
`default_nettype none

package mefst_pkg;

  localparam int CHANNELS_DEFAULT = 16;
  localparam int QUEUE_DEPTH      = 2;

  // shadow layout per channel: 128 controllers, program, pressure, bend
  localparam int          SHADOW_W    = 14;
  localparam int          IDX_SPAN    = 256;
  localparam int          ENTRIES     = 131;
  localparam logic [7:0]  IDX_PROGRAM = 8'd128;
  localparam logic [7:0]  IDX_PRESS   = 8'd129;
  localparam logic [7:0]  IDX_BEND    = 8'd130;
  localparam logic [7:0]  IDX_PERIOD  = 8'd131;

  // tick period
  localparam int           PERIOD_W     = 34;
  localparam logic [33:0]  PERIOD_RESET = 34'd1041666;
  localparam logic [9:0]   TEMPO_SCALE  = 10'd1000;

  // tdata widths
  localparam int IN_TDATA_W  = 72;
  localparam int ITEM_W      = 67;
  localparam int OUT_TDATA_W = 136;
  localparam int RES_W       = 129;

  // status high nibble
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CONTROL  = 4'hB;
  localparam logic [3:0] KIND_PROGRAM  = 4'hC;
  localparam logic [3:0] KIND_PRESSURE = 4'hD;
  localparam logic [3:0] KIND_BEND     = 4'hE;
  localparam logic [3:0] KIND_SYSTEM   = 4'hF;

  // status low nibble for system events
  localparam logic [3:0] SYS_META      = 4'hF;
  localparam logic [3:0] SYS_SYSEX     = 4'h0;
  localparam logic [3:0] SYS_SYSEX_ESC = 4'h7;

  // meta types
  localparam logic [13:0] META_TEMPO = 14'h51;
  localparam logic [13:0] META_TSIG  = 14'h58;
  localparam logic [13:0] META_KSIG  = 14'h59;

  // item opcodes
  localparam logic OPC_EVENT = 1'b0;
  localparam logic OPC_READ  = 1'b1;

  // forwarded kinds
  localparam logic [2:0] FWD_NOTE_OFF = 3'd0;
  localparam logic [2:0] FWD_NOTE_ON  = 3'd1;
  localparam logic [2:0] FWD_CONTROL  = 3'd2;
  localparam logic [2:0] FWD_PROGRAM  = 3'd3;
  localparam logic [2:0] FWD_BEND     = 3'd4;
  localparam logic [2:0] FWD_SYSEX    = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_READ_PERIOD,
    OP_WRITE,
    OP_TEMPO,
    OP_TSIG,
    OP_KSIG
  } cmd_op_t;

  // input beat, last field lowest
  typedef struct packed {
    logic [7:0]  read_index;
    logic [3:0]  read_channel;
    logic [31:0] param2;
    logic [13:0] param1;
    logic [7:0]  status;
    logic        opcode;
  } item_t;

  // classified work handed from front to back
  typedef struct packed {
    cmd_op_t     op;
    logic        fwd_valid;
    logic [2:0]  fwd_kind;
    logic [3:0]  fwd_channel;
    logic [13:0] fwd_p1;
    logic [6:0]  fwd_p2;
    logic [3:0]  chan;
    logic [7:0]  idx;
    logic [23:0] data;
  } cmd_t;

  // result beat, last field lowest
  typedef struct packed {
    logic [33:0] read_value;
    logic [15:0] key_signature;
    logic [7:0]  beat_unit;
    logic [7:0]  beats_per_bar;
    logic [33:0] tick_period_ns;
    logic [6:0]  forward_p2;
    logic [13:0] forward_p1;
    logic [3:0]  forward_channel;
    logic [2:0]  forward_kind;
    logic        forward_valid;
  } res_t;

  // midi power-on value of a shadow entry
  function automatic logic [SHADOW_W-1:0] shadow_default(input logic [7:0] idx);
    logic [SHADOW_W-1:0] v;
    v = '0;
    case (idx) inside
      8'd7:          v = 14'd100;
      8'd10:         v = 14'd64;
      8'd11:         v = 14'd127;
      [8'd71:8'd78]: v = 14'd64;
      default:       v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/midi_event_filter_state_tracker_core.sv
// top level of the midi event filter and channel state tracker
// flow: an input beat is queued, popped into the back end's command register, then executed
//   into the result register; a tempo meta event holds the back end while the divider runs
// the back end pops a new beat only when idle and its result register is free
// reset: synchronous, clears control state and runs a shadow clearing pass of
//   CHANNELS*131 entries (2096 by default), during which no input beat is taken
`default_nettype none

module midi_event_filter_state_tracker_core
  import mefst_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  wire                    clk,
  input  wire                    rst,
  // configuration writes
  input  wire                    cfg_we,
  input  wire  [1:0]             cfg_index,
  input  wire  [15:0]            cfg_data,
  // input stream
  input  wire                    s_tvalid,
  output logic                   s_tready,
  // opcode, status, param1, param2, read_channel, read_index, zero pad
  input  wire  [IN_TDATA_W-1:0]  s_tdata,
  // output stream
  output logic                   m_tvalid,
  input  wire                    m_tready,
  // forward_valid, forward_kind, forward_channel, forward_p1, forward_p2,
  // tick_period_ns, beats_per_bar, beat_unit, key_signature, read_value, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // register indexes
  localparam logic [1:0] REG_MUTE  = 2'd0;
  localparam logic [1:0] REG_SOLO  = 2'd1;
  localparam logic [1:0] REG_SYSEX = 2'd2;
  localparam logic [1:0] REG_TICKS = 2'd3;

  // configuration registers
  logic [15:0] mute_mask;
  logic [15:0] solo_mask;
  logic        send_sysex;
  logic [14:0] ticks_per_quarter;

  item_t item;
  cmd_t  push_cmd;
  cmd_t  q_cmd;
  logic  push;
  logic  pop;
  logic  q_valid;
  logic  q_full;
  logic  clearing;
  res_t  out_res;

  // input beat fields, opcode in the lowest bit
  assign item = item_t'(s_tdata[ITEM_W-1:0]);

  // result register drives the output beat directly
  assign m_tdata = {(OUT_TDATA_W - RES_W)'(0), out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      mute_mask         <= '0;
      solo_mask         <= '0;
      send_sysex        <= 1'b1;
      ticks_per_quarter <= 15'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MUTE:  mute_mask         <= cfg_data;
        REG_SOLO:  solo_mask         <= cfg_data;
        REG_SYSEX: send_sysex        <= cfg_data[0];
        REG_TICKS: ticks_per_quarter <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // front: filtering by mute and solo, event decode
  mefst_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .item       (item),
    .mute_mask  (mute_mask),
    .solo_mask  (solo_mask),
    .send_sysex (send_sysex),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (push),
    .cmd        (push_cmd)
  );

  // decouples decode from the slower back end
  mefst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_cmd    (q_cmd)
  );

  // back: shadow table, tempo divide, signature state, output register
  mefst_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .pop               (pop),
    .ticks_per_quarter (ticks_per_quarter),
    .clearing          (clearing),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_res           (out_res)
  );

endmodule

`default_nettype wire

### hw/rtl/mefst_front.sv
// front end: takes input beats and classifies them into commands
`default_nettype none

module mefst_front
  import mefst_pkg::*;
(
  input  wire         s_tvalid,
  output logic        s_tready,
  input  item_t       item,
  input  wire  [15:0] mute_mask,
  input  wire  [15:0] solo_mask,
  input  wire         send_sysex,
  input  wire         q_full,
  input  wire         clearing,
  output logic        push,
  output cmd_t        cmd
);

  logic [3:0] kind;
  logic [3:0] ch;
  logic [2:0] exp_sat;

  assign kind     = item.status[7:4];
  assign ch       = item.status[3:0];
  assign exp_sat  = (item.param2[23:16] > 8'd7) ? 3'd7 : item.param2[18:16];
  assign s_tready = !q_full && !clearing;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd    = '0;
    cmd.op = OP_NONE;
    if (item.opcode == OPC_READ) begin
      cmd.chan = item.read_channel;
      cmd.idx  = item.read_index;
      if (item.read_index == IDX_PERIOD) begin
        cmd.op = OP_READ_PERIOD;
      end else if (item.read_index < 8'(ENTRIES)) begin
        cmd.op = OP_READ;
      end
    end else begin
      cmd.chan        = ch;
      cmd.fwd_channel = ch;
      cmd.fwd_p1      = item.param1;
      unique case (kind)
        KIND_NOTE_OFF: begin
          cmd.fwd_valid = 1'b1;
          cmd.fwd_kind  = FWD_NOTE_OFF;
        end
        KIND_NOTE_ON: begin
          if (!mute_mask[ch] && (solo_mask == '0 || solo_mask[ch])) begin
            cmd.fwd_valid = 1'b1;
            cmd.fwd_kind  = FWD_NOTE_ON;
            cmd.fwd_p2    = item.param2[6:0];
          end
        end
        KIND_CONTROL: begin
          if (item.param1 <= 14'd127) begin
            cmd.op        = OP_WRITE;
            cmd.idx       = {1'b0, item.param1[6:0]};
            cmd.data      = 24'(item.param2[13:0]);
            cmd.fwd_valid = 1'b1;
            cmd.fwd_kind  = FWD_CONTROL;
            cmd.fwd_p2    = item.param2[6:0];
          end
        end
        KIND_PROGRAM: begin
          cmd.op        = OP_WRITE;
          cmd.idx       = IDX_PROGRAM;
          cmd.data      = 24'(item.param1);
          cmd.fwd_valid = 1'b1;
          cmd.fwd_kind  = FWD_PROGRAM;
        end
        KIND_PRESSURE: begin
          cmd.op   = OP_WRITE;
          cmd.idx  = IDX_PRESS;
          cmd.data = 24'(item.param1);
        end
        KIND_BEND: begin
          cmd.op        = OP_WRITE;
          cmd.idx       = IDX_BEND;
          cmd.data      = 24'(item.param1);
          cmd.fwd_valid = 1'b1;
          cmd.fwd_kind  = FWD_BEND;
        end
        KIND_SYSTEM: begin
          if (ch == SYS_META) begin
            if (item.param1 == META_TEMPO) begin
              cmd.op   = OP_TEMPO;
              cmd.data = item.param2[23:0];
            end else if (item.param1 == META_TSIG) begin
              cmd.op   = OP_TSIG;
              cmd.data = {13'd0, exp_sat, item.param2[31:24]};
            end else if (item.param1 == META_KSIG) begin
              cmd.op   = OP_KSIG;
              cmd.data = {8'd0, item.param2[15:0]};
            end
          end else if ((ch == SYS_SYSEX || ch == SYS_SYSEX_ESC) && send_sysex) begin
            cmd.fwd_valid   = 1'b1;
            cmd.fwd_kind    = FWD_SYSEX;
            cmd.fwd_channel = '0;
          end
        end
        default: ;
      endcase
      // nothing forwarded means all forward fields read zero
      if (!cmd.fwd_valid) begin
        cmd.fwd_channel = '0;
        cmd.fwd_p1      = '0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mefst_queue.sv
// short command queue between front and back
`default_nettype none

module mefst_queue
  import mefst_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  input  cmd_t  push_cmd,
  input  wire   pop,
  output logic  q_valid,
  output logic  q_full,
  output cmd_t  q_cmd
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CW'(QUEUE_DEPTH));
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mefst_back.sv
// back end: shadow memory, tempo divider, signature registers and result register
`default_nettype none

module mefst_back
  import mefst_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  input  wire  [14:0] ticks_per_quarter,
  output logic        clearing,
  output logic        out_valid,
  input  wire         out_ready,
  output res_t        out_res
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * IDX_SPAN;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_t;

  state_t state;

  logic [SHADOW_W-1:0] shadow [DEPTH];
  logic [SHADOW_W-1:0] rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SHADOW_W-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;

  logic [CH_W-1:0] clr_ch;
  logic [7:0]      clr_idx;

  cmd_t        cur;
  logic [33:0] tick_period;
  logic [7:0]  numerator;
  logic [7:0]  denominator;
  logic [15:0] key_sig;

  // restoring divider
  logic [33:0] quo;
  logic [14:0] rem;
  logic [5:0]  div_cnt;
  logic [14:0] divisor;
  logic [15:0] trial;
  logic        ge;
  logic [14:0] rem_step;
  logic [33:0] quo_step;

  logic   cur_chan_ok;
  logic   q_chan_ok;
  res_t   res_base;

  assign clearing    = (state == ST_CLEAR);
  assign cur_chan_ok = ({1'b0, cur.chan} < 5'(CHANNELS));
  assign q_chan_ok   = ({1'b0, q_cmd.chan} < 5'(CHANNELS));
  assign pop         = (state == ST_IDLE) && q_valid && (!out_valid || out_ready);

  assign divisor  = (ticks_per_quarter == '0) ? 15'd1 : ticks_per_quarter;
  assign trial    = {rem, quo[33]};
  assign ge       = (trial >= {1'b0, divisor});
  assign rem_step = ge ? 15'(trial - {1'b0, divisor}) : trial[14:0];
  assign quo_step = {quo[32:0], ge};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'({cur.chan, cur.idx});
    mem_wdata = cur.data[SHADOW_W-1:0];
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = AW'({4'(clr_ch), clr_idx});
      mem_wdata = shadow_default(clr_idx);
    end else if (state == ST_EXEC && cur.op == OP_WRITE && cur_chan_ok) begin
      mem_we = 1'b1;
    end
    mem_re    = pop && (q_cmd.op == OP_READ) && q_chan_ok;
    mem_raddr = AW'({q_cmd.chan, q_cmd.idx});
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shadow[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= shadow[mem_raddr];
    end
  end

  // result with the state this command leaves behind
  always_comb begin
    res_base                 = '0;
    res_base.forward_valid   = cur.fwd_valid;
    res_base.forward_kind    = cur.fwd_kind;
    res_base.forward_channel = cur.fwd_channel;
    res_base.forward_p1      = cur.fwd_p1;
    res_base.forward_p2      = cur.fwd_p2;
    // last divider step carries the new period
    res_base.tick_period_ns  = (state == ST_DIV) ? quo_step : tick_period;
    res_base.beats_per_bar   = (cur.op == OP_TSIG) ? cur.data[7:0] : numerator;
    res_base.beat_unit       = (cur.op == OP_TSIG) ? (8'd1 << cur.data[10:8]) : denominator;
    res_base.key_signature   = (cur.op == OP_KSIG) ? cur.data[15:0] : key_sig;
    case (cur.op)
      OP_READ:        res_base.read_value = cur_chan_ok ? 34'(rd_data) : '0;
      OP_READ_PERIOD: res_base.read_value = tick_period;
      default:        res_base.read_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_ch      <= '0;
      clr_idx     <= '0;
      out_valid   <= 1'b0;
      tick_period <= PERIOD_RESET;
      numerator   <= 8'd4;
      denominator <= 8'd4;
      key_sig     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_idx == 8'(ENTRIES - 1)) begin
            clr_idx <= '0;
            if (clr_ch == CH_W'(CHANNELS - 1)) begin
              state <= ST_IDLE;
            end else begin
              clr_ch <= clr_ch + 1'b1;
            end
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cur   <= q_cmd;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cur.op == OP_TEMPO) begin
            quo     <= 34'(cur.data) * 34'(TEMPO_SCALE);
            rem     <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end else begin
            if (cur.op == OP_TSIG) begin
              numerator   <= res_base.beats_per_bar;
              denominator <= res_base.beat_unit;
            end
            if (cur.op == OP_KSIG) begin
              key_sig <= res_base.key_signature;
            end
            out_res   <= res_base;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_DIV: begin
          quo     <= quo_step;
          rem     <= rem_step;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'(PERIOD_W - 1)) begin
            tick_period <= quo_step;
            out_res     <= res_base;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sim/midi_event_filter_state_tracker_core_test.sv
// self-checking testbench of the midi event filter and channel state tracker core
`default_nettype none

module midi_event_filter_state_tracker_core_test;
  import mefst_pkg::*;

  // configuration register indexes
  localparam logic [1:0] REG_MUTE  = 2'd0;
  localparam logic [1:0] REG_SOLO  = 2'd1;
  localparam logic [1:0] REG_SYSEX = 2'd2;
  localparam logic [1:0] REG_TPQ   = 2'd3;

  // codes the block does not handle, used to check they are ignored
  localparam logic [3:0]  KIND_POLY_PRESS = 4'hA;
  localparam logic [3:0]  KIND_DATA_BYTE  = 4'h4;
  localparam logic [3:0]  SYS_UNDEFINED   = 4'h5;
  localparam logic [13:0] META_END_TRACK  = 14'h2F;

  localparam int N_CH        = CHANNELS_DEFAULT;
  localparam int N_ENTRIES   = ENTRIES;
  localparam int SHOW_LIMIT  = 10;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = '0;
  logic [15:0]            cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  midi_event_filter_state_tracker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // tracker state as the testbench sees it
  logic [13:0] shadow_mem [N_CH][N_ENTRIES];
  logic [33:0] tick_ns = PERIOD_RESET;
  logic [7:0]  ts_num = 8'd4;
  logic [7:0]  ts_den = 8'd4;
  logic [15:0] key_reg = '0;

  // register copies, at their reset values
  logic [15:0] mute_bits = '0;
  logic [15:0] solo_bits = '0;
  logic        sysex_on = 1'b1;
  logic [14:0] tpq_val = 15'd480;

  item_t event_backlog [$];     // items waiting for the driver
  res_t  expected_results [$];  // one per accepted input beat

  int mismatches = 0;
  int results_seen = 0;

  // apply one item to the tracker state and return the result beat it causes
  function automatic res_t step_tracker(input item_t it);
    res_t        r;
    logic [3:0]  kind;
    logic [3:0]  chan;
    logic [7:0]  expo;
    logic [63:0] prod;
    logic [63:0] divisor;
    r = '0;
    kind = it.status[7:4];
    chan = it.status[3:0];
    if (it.opcode == OPC_READ) begin
      // entry 131 is the tick period for any channel, above that reads zero
      if (it.read_index == IDX_PERIOD) begin
        r.read_value = tick_ns;
      end else if (it.read_index < IDX_PERIOD) begin
        r.read_value = 34'(shadow_mem[it.read_channel][it.read_index]);
      end
    end else begin
      case (kind)
        KIND_NOTE_OFF: begin
          r.forward_valid   = 1'b1;
          r.forward_kind    = FWD_NOTE_OFF;
          r.forward_channel = chan;
          r.forward_p1      = it.param1;
        end
        KIND_NOTE_ON: begin
          // mute wins, then a nonzero solo mask lets only its channels through
          if (!mute_bits[chan] && (solo_bits == '0 || solo_bits[chan])) begin
            r.forward_valid   = 1'b1;
            r.forward_kind    = FWD_NOTE_ON;
            r.forward_channel = chan;
            r.forward_p1      = it.param1;
            r.forward_p2      = it.param2[6:0];
          end
        end
        KIND_CONTROL: begin
          // controller numbers past 127 drop the whole event
          if (it.param1 < 14'd128) begin
            shadow_mem[chan][it.param1[6:0]] = it.param2[13:0];
            r.forward_valid   = 1'b1;
            r.forward_kind    = FWD_CONTROL;
            r.forward_channel = chan;
            r.forward_p1      = it.param1;
            r.forward_p2      = it.param2[6:0];
          end
        end
        KIND_PROGRAM: begin
          shadow_mem[chan][IDX_PROGRAM] = it.param1;
          r.forward_valid   = 1'b1;
          r.forward_kind    = FWD_PROGRAM;
          r.forward_channel = chan;
          r.forward_p1      = it.param1;
        end
        KIND_PRESSURE: begin
          // shadow only, never forwarded
          shadow_mem[chan][IDX_PRESS] = it.param1;
        end
        KIND_BEND: begin
          shadow_mem[chan][IDX_BEND] = it.param1;
          r.forward_valid   = 1'b1;
          r.forward_kind    = FWD_BEND;
          r.forward_channel = chan;
          r.forward_p1      = it.param1;
        end
        KIND_SYSTEM: begin
          if (chan == SYS_META) begin
            case (it.param1)
              META_TEMPO: begin
                // zero ticks per quarter divides as one
                divisor = (tpq_val == '0) ? 64'd1 : 64'(tpq_val);
                prod    = 64'(it.param2[23:0]) * 64'd1000;
                tick_ns = 34'(prod / divisor);
              end
              META_TSIG: begin
                expo = it.param2[23:16];
                if (expo > 8'd7) expo = 8'd7;
                ts_num = it.param2[31:24];
                ts_den = 8'd1 << expo;
              end
              META_KSIG: begin
                key_reg = it.param2[15:0];
              end
              default: begin
              end
            endcase
          end else if (chan == SYS_SYSEX || chan == SYS_SYSEX_ESC) begin
            if (sysex_on) begin
              r.forward_valid = 1'b1;
              r.forward_kind  = FWD_SYSEX;
              r.forward_p1    = it.param1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    r.tick_period_ns = tick_ns;
    r.beats_per_bar  = ts_num;
    r.beat_unit      = ts_den;
    r.key_signature  = key_reg;
    return r;
  endfunction

  function automatic item_t make_item(input logic opc, input logic [7:0] st,
                                      input logic [13:0] p1, input logic [31:0] p2,
                                      input logic [3:0] rch, input logic [7:0] ridx);
    item_t it;
    it.opcode       = opc;
    it.status       = st;
    it.param1       = p1;
    it.param2       = p2;
    it.read_channel = rch;
    it.read_index   = ridx;
    return it;
  endfunction

  // mostly well-formed events with random content, some reads and some noise
  function automatic item_t random_item();
    item_t it;
    int    sel;
    it.opcode       = OPC_EVENT;
    it.status       = 8'($urandom);
    it.param1       = 14'($urandom);
    it.param2       = $urandom;
    it.read_channel = 4'($urandom);
    it.read_index   = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      it.opcode = OPC_READ;
      if ($urandom_range(0, 9) != 0) it.read_index = 8'($urandom_range(0, 131));
    end else if (sel < 36) begin
      it.status[7:4] = ($urandom_range(0, 2) == 0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
    end else if (sel < 50) begin
      it.status[7:4] = KIND_CONTROL;
      if ($urandom_range(0, 9) != 0) it.param1 = 14'($urandom_range(0, 127));
    end else if (sel < 56) begin
      it.status[7:4] = KIND_PROGRAM;
    end else if (sel < 61) begin
      it.status[7:4] = KIND_PRESSURE;
    end else if (sel < 68) begin
      it.status[7:4] = KIND_BEND;
    end else if (sel < 82) begin
      it.status = {KIND_SYSTEM, SYS_META};
      case ($urandom_range(0, 3))
        0:       it.param1 = META_TEMPO;
        1:       it.param1 = META_TSIG;
        2:       it.param1 = META_KSIG;
        default: begin
        end
      endcase
    end else if (sel < 90) begin
      it.status = {KIND_SYSTEM, $urandom_range(0, 1) ? SYS_SYSEX : SYS_SYSEX_ESC};
    end else if (sel < 94) begin
      it.status[7:4] = KIND_SYSTEM;
    end
    return it;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      // a beat taken at this edge is predicted now, while registers are stable
      if (s_tvalid) expected_results.push_back(step_tracker(item_t'(s_tdata[ITEM_W-1:0])));
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (event_backlog.size() != 0) begin
        s_tdata  <= {{(IN_TDATA_W-ITEM_W){1'b0}}, event_backlog.pop_front()};
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: a stall pattern that changes each time the 8-bit pattern counter wraps, plus one long hold-off
  logic [7:0] pat_cnt = '0;
  logic [1:0] pat_mode = '0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;

  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 8'd1;
    if (pat_cnt == '0) pat_mode <= 2'($urandom_range(0, 3));
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && results_seen >= 600) begin
      // long hold so the block fills and backs up its input
      hold_done <= 1'b1;
      hold_left <= 400;
      m_tready  <= 1'b0;
    end else begin
      case (pat_mode)
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= pat_cnt[3];
      endcase
    end
  end

  task automatic report_field(input string what, input logic [33:0] got,
                              input logic [33:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  // result checking against the oldest expectation
  res_t seen_res;
  res_t want_res;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_res = res_t'(m_tdata[RES_W-1:0]);
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected result beat 0x%0h", m_tdata);
      end else begin
        want_res = expected_results.pop_front();
        report_field("forward_valid", 34'(seen_res.forward_valid),
                     34'(want_res.forward_valid));
        report_field("forward_kind", 34'(seen_res.forward_kind),
                     34'(want_res.forward_kind));
        report_field("forward_channel", 34'(seen_res.forward_channel),
                     34'(want_res.forward_channel));
        report_field("forward_p1", 34'(seen_res.forward_p1), 34'(want_res.forward_p1));
        report_field("forward_p2", 34'(seen_res.forward_p2), 34'(want_res.forward_p2));
        report_field("tick_period_ns", seen_res.tick_period_ns, want_res.tick_period_ns);
        report_field("beats_per_bar", 34'(seen_res.beats_per_bar),
                     34'(want_res.beats_per_bar));
        report_field("beat_unit", 34'(seen_res.beat_unit), 34'(want_res.beat_unit));
        report_field("key_signature", 34'(seen_res.key_signature),
                     34'(want_res.key_signature));
        report_field("read_value", seen_res.read_value, want_res.read_value);
      end
    end
  end

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MUTE:  mute_bits = val;
      REG_SOLO:  solo_bits = val;
      REG_SYSEX: sysex_on  = val[0];
      default:   tpq_val   = val[14:0];
    endcase
  endtask

  task automatic set_regs(input logic [15:0] mute, input logic [15:0] solo,
                          input logic sysex, input logic [14:0] tpq);
    write_reg(REG_MUTE, mute);
    write_reg(REG_SOLO, solo);
    write_reg(REG_SYSEX, {15'd0, sysex});
    write_reg(REG_TPQ, {1'b0, tpq});
  endtask

  // every item yields a result, so nothing queued, offered or owed means idle
  task automatic wait_idle();
    while (event_backlog.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) event_backlog.push_back(random_item());
  endtask

  initial begin
    // controller defaults: volume 100, pan 64, expression 127, sound controllers 64
    for (int c = 0; c < N_CH; c++) begin
      for (int k = 0; k < N_ENTRIES; k++) shadow_mem[c][k] = '0;
      shadow_mem[c][7]  = 14'd100;
      shadow_mem[c][10] = 14'd64;
      shadow_mem[c][11] = 14'd127;
      for (int k = 71; k <= 78; k++) shadow_mem[c][k] = 14'd64;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset register values
    event_backlog.push_back(make_item(OPC_READ, 8'h00, 14'd0, 32'd0, 4'd0, 8'd7));
    event_backlog.push_back(make_item(OPC_READ, 8'h00, 14'd0, 32'd0, 4'hF, IDX_PERIOD));
    // read past the tick period entry
    event_backlog.push_back(make_item(OPC_READ, 8'hFF, 14'h3FFF, 32'hFFFF_FFFF, 4'hF,
                                      8'hFF));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_NOTE_OFF, 4'h0}, 14'd0,
                                      32'hFFFF_FFFF, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_NOTE_ON, 4'hF}, 14'h3FFF,
                                      32'hFFFF_FFFF, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_NOTE_ON, 4'h0}, 14'd0, 32'd0,
                                      4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_CONTROL, 4'h3}, 14'd127,
                                      32'hFFFF_FFFF, 4'd0, 8'd0));
    // controller number past 127 is dropped
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_CONTROL, 4'h3}, 14'd128, 32'd5,
                                      4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_CONTROL, 4'hF}, 14'd0, 32'h2A,
                                      4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_READ, 8'h00, 14'd0, 32'd0, 4'd3, 8'd127));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_PROGRAM, 4'h5}, 14'h3FFF, 32'd0,
                                      4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_PRESSURE, 4'h5}, 14'h1234,
                                      32'hFFFF_FFFF, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_BEND, 4'h5}, 14'h2000,
                                      32'hFFFF_FFFF, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_READ, 8'h00, 14'd0, 32'd0, 4'd5, IDX_PROGRAM));
    event_backlog.push_back(make_item(OPC_READ, 8'h00, 14'd0, 32'd0, 4'd5, IDX_PRESS));
    event_backlog.push_back(make_item(OPC_READ, 8'h00, 14'd0, 32'd0, 4'd5, IDX_BEND));
    // largest tempo, upper byte of the word discarded
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_META}, META_TEMPO,
                                      32'hFFFF_FFFF, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_READ, 8'h00, 14'd0, 32'd0, 4'd9, IDX_PERIOD));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_META}, META_TEMPO,
                                      32'hFF00_0000, 4'd0, 8'd0));
    // beat exponent past 7 saturates
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_META}, META_TSIG,
                                      32'hFF0A_0000, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_META}, META_TSIG,
                                      32'h0303_0000, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_META}, META_KSIG,
                                      32'hFFFF_ABCD, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_META}, META_END_TRACK,
                                      32'hFFFF_FFFF, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_SYSEX}, 14'h3FFF,
                                      32'hFFFF_FFFF, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_SYSEX_ESC}, 14'd5,
                                      32'd0, 4'd0, 8'd0));
    // statuses that must be ignored
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_SYSTEM, SYS_UNDEFINED}, 14'd9,
                                      32'd9, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_POLY_PRESS, 4'h2}, 14'd60,
                                      32'd90, 4'd0, 8'd0));
    event_backlog.push_back(make_item(OPC_EVENT, {KIND_DATA_BYTE, 4'h0}, 14'd1, 32'd1,
                                      4'd0, 8'd0));
    queue_random(200);
    wait_idle();

    // random mute, sysex dropped, smallest division
    set_regs(16'($urandom), '0, 1'b0, 15'd1);
    queue_random(450);
    wait_idle();

    // solo only, largest division
    set_regs('0, 16'($urandom_range(1, 16'hFFFF)), 1'b1, 15'h7FFF);
    queue_random(450);
    wait_idle();

    // everything muted and soloed, zero division
    set_regs(16'hFFFF, 16'hFFFF, 1'b1, 15'd0);
    queue_random(250);
    wait_idle();

    // random registers; the sender drains fully halfway through
    set_regs(16'($urandom), ($urandom_range(0, 1) ? 16'($urandom) : 16'd0),
             1'($urandom), 15'($urandom_range(1, 15'h7FFF)));
    queue_random(300);
    wait_idle();
    queue_random(300);
    wait_idle();

    // allow a tempo divide's worth of cycles for anything stray
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("midi_event_filter_state_tracker_core_test: done, clean");
    end else begin
      $display("midi_event_filter_state_tracker_core_test: done, errors");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("midi_event_filter_state_tracker_core_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
